### design/gmc_pkg.sv
// ----------------------------------------------------------------------------
// gmc_pkg
// Shared types and constants for the gate motor controller.
// ----------------------------------------------------------------------------
package gmc_pkg;

  localparam int unsigned TravelW = 12;
  localparam int unsigned DwellW  = 9;
  localparam int unsigned PeriodW = 8;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [TravelW-1:0] TravelMax     = '1;
  localparam logic [DwellW-1:0]  DwellMax      = '1;
  localparam logic [TravelW-1:0] TravelLimRst  = 12'd3600;
  localparam logic [PeriodW-1:0] EmgPeriodRst  = 8'd150;
  localparam logic [PeriodW-1:0] BlinkHalfRst  = 8'd50;

  typedef enum logic [2:0] {
    MODE_INIT      = 3'd0,
    MODE_OPENING   = 3'd1,
    MODE_CLOSING   = 3'd2,
    MODE_CLOSED    = 3'd3,
    MODE_OPEN      = 3'd4,
    MODE_EMERGENCY = 3'd5,
    MODE_ERROR     = 3'd6,
    MODE_WAITING   = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    REG_TRAVEL_LIMIT = 2'd0,
    REG_EMG_PERIOD   = 2'd1,
    REG_BLINK_HALF   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [TravelW-1:0] travel_limit;
    logic [PeriodW-1:0] emergency_check_period;
    logic [PeriodW-1:0] error_blink_half;
  } cfg_t;

  typedef struct packed {
    logic limit_open;
    logic limit_closed;
    logic cmd_open;
    logic cmd_close;
    logic beam_fault;
    logic timer_tick;
  } sample_t;

  typedef struct packed {
    logic  motor_open;
    logic  motor_close;
    logic  led_moving;
    logic  led_alarm;
    mode_e mode;
  } result_t;

endpackage

### design/gmc_fsm.sv
// ----------------------------------------------------------------------------
// gmc_fsm
// Gate mode state machine: travel timer, dwell counter and result decode.
// ----------------------------------------------------------------------------
module gmc_fsm
  import gmc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  sample_t sample_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  mode_e              mode_q, mode_d;
  mode_e              prev_q, prev_d;
  logic [TravelW-1:0] travel_q, travel_d;
  logic [DwellW-1:0]  dwell_q, dwell_d;

  logic               moving;
  logic [TravelW-1:0] travel_base;
  logic [DwellW-1:0]  dwell_inc;
  logic               enter;
  mode_e              target;
  logic               timeout;
  logic               both_lim;

  always_comb begin
    moving      = (mode_q == MODE_OPENING) || (mode_q == MODE_CLOSING);
    travel_base = (sample_i.cmd_open || sample_i.cmd_close) ? '0 : travel_q;
    travel_d    = travel_q;
    if (sample_i.timer_tick) begin
      if (moving) begin
        travel_d = (travel_base != TravelMax) ? travel_base + 1'b1 : travel_base;
      end else begin
        travel_d = '0;
      end
    end
    timeout   = travel_d >= cfg_i.travel_limit;
    both_lim  = sample_i.limit_open && sample_i.limit_closed;
    dwell_inc = (dwell_q != DwellMax) ? dwell_q + 1'b1 : dwell_q;

    enter   = 1'b0;
    target  = mode_q;
    dwell_d = dwell_q;
    unique case (mode_q)
      MODE_INIT, MODE_CLOSED, MODE_OPEN: begin
        enter  = 1'b1;
        target = MODE_WAITING;
      end
      MODE_WAITING: begin
        if (both_lim) begin
          enter = 1'b1; target = MODE_ERROR;
        end else if (!sample_i.limit_open && !sample_i.limit_closed &&
                     !sample_i.beam_fault) begin
          enter = 1'b1; target = MODE_CLOSING;
        end else if (sample_i.cmd_open && !sample_i.beam_fault) begin
          enter = 1'b1; target = MODE_OPENING;
        end else if (sample_i.cmd_close && !sample_i.beam_fault) begin
          enter = 1'b1; target = MODE_CLOSING;
        end else if (sample_i.beam_fault &&
                     (sample_i.limit_open || sample_i.limit_closed)) begin
          enter = 1'b1; target = MODE_ERROR;
        end
      end
      MODE_OPENING: begin
        if (both_lim) begin
          enter = 1'b1; target = MODE_ERROR;
        end else if (sample_i.limit_open) begin
          enter = 1'b1; target = MODE_OPEN;
        end else if (sample_i.beam_fault) begin
          enter = 1'b1; target = MODE_EMERGENCY;
        end else if (sample_i.cmd_close) begin
          enter = 1'b1; target = MODE_CLOSING;
        end else if (timeout) begin
          enter = 1'b1; target = MODE_ERROR;
        end
      end
      MODE_CLOSING: begin
        if (both_lim) begin
          enter = 1'b1; target = MODE_ERROR;
        end else if (sample_i.limit_closed) begin
          enter = 1'b1; target = MODE_CLOSED;
        end else if (sample_i.beam_fault) begin
          enter = 1'b1; target = MODE_EMERGENCY;
        end else if (sample_i.cmd_open) begin
          enter = 1'b1; target = MODE_OPENING;
        end else if (timeout) begin
          enter = 1'b1; target = MODE_ERROR;
        end
      end
      MODE_EMERGENCY: begin
        dwell_d = dwell_inc;
        if (dwell_inc >= {1'b0, cfg_i.emergency_check_period}) begin
          if (!sample_i.beam_fault) begin
            enter = 1'b1; target = prev_q;
          end else begin
            dwell_d = '0;
          end
        end
      end
      MODE_ERROR: begin
        dwell_d = dwell_inc;
        if (dwell_inc >= {cfg_i.error_blink_half, 1'b0}) begin
          enter = 1'b1; target = MODE_WAITING;
        end
      end
    endcase

    mode_d = mode_q;
    prev_d = prev_q;
    if (enter) begin
      prev_d  = mode_q;
      mode_d  = target;
      dwell_d = '0;
    end

    result_o = '{motor_open: 1'b0, motor_close: 1'b0, led_moving: 1'b0,
                 led_alarm: 1'b0, mode: mode_d};
    case (mode_d)
      MODE_OPENING: begin
        result_o.motor_open = 1'b1;
        result_o.led_moving = 1'b1;
      end
      MODE_CLOSING: begin
        result_o.motor_close = 1'b1;
        result_o.led_moving  = 1'b1;
      end
      MODE_EMERGENCY: result_o.led_alarm = 1'b1;
      MODE_ERROR:     result_o.led_alarm = dwell_d < {1'b0, cfg_i.error_blink_half};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_INIT;
      prev_q   <= MODE_INIT;
      travel_q <= '0;
      dwell_q  <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      prev_q   <= prev_d;
      travel_q <= travel_d;
      dwell_q  <= dwell_d;
    end
  end

endmodule

### design/gate_motor_controller.sv
// ----------------------------------------------------------------------------
// gate_motor_controller
// Motorized gate controller with limit, timeout and photocell handling.
// ----------------------------------------------------------------------------
// One sample item is taken per clock unless stalled and gives one result
// item, the drives and LEDs of the mode after that sample. The mode update
// is a single pass of next-state logic from the state registers into the
// result register; a two-entry output buffer (result register plus skid
// register) lets the input keep flowing while one result waits, so the
// input stalls only once both entries are full. Registers: travel_limit at
// 0x0, emergency_check_period at 0x4, error_blink_half at 0x8.
module gate_motor_controller
  import gmc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             limit_open_i,
  input  logic             limit_closed_i,
  input  logic             cmd_open_i,
  input  logic             cmd_close_i,
  input  logic             beam_fault_i,
  input  logic             timer_tick_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             motor_open_o,
  output logic             motor_close_o,
  output logic             led_moving_o,
  output logic             led_alarm_o,
  output logic [2:0]       mode_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  sample_t  sample;
  result_t  result;
  logic     accept;
  logic     out_pop;
  logic     out_valid_q, skid_valid_q;
  result_t  out_q, skid_q;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_TRAVEL_LIMIT: prdata = DataW'(cfg_q.travel_limit);
      REG_EMG_PERIOD:   prdata = DataW'(cfg_q.emergency_check_period);
      REG_BLINK_HALF:   prdata = DataW'(cfg_q.error_blink_half);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.travel_limit           <= TravelLimRst;
      cfg_q.emergency_check_period <= EmgPeriodRst;
      cfg_q.error_blink_half       <= BlinkHalfRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRAVEL_LIMIT: cfg_q.travel_limit           <= pwdata[TravelW-1:0];
        REG_EMG_PERIOD:   cfg_q.emergency_check_period <= pwdata[PeriodW-1:0];
        REG_BLINK_HALF:   cfg_q.error_blink_half       <= pwdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // item handshake
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_pop    = out_valid_q && !out_stall_i;

  assign sample = '{limit_open: limit_open_i, limit_closed: limit_closed_i,
                    cmd_open: cmd_open_i, cmd_close: cmd_close_i,
                    beam_fault: beam_fault_i, timer_tick: timer_tick_i};

  gmc_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || out_pop) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign motor_open_o  = out_q.motor_open;
  assign motor_close_o = out_q.motor_close;
  assign led_moving_o  = out_q.led_moving;
  assign led_alarm_o   = out_q.led_alarm;
  assign mode_o        = out_q.mode;

endmodule

### design/gmc_checker.sv
// ----------------------------------------------------------------------------
// gmc_checker
// Port-level checks for the gate motor controller, bound to the top level.
// ----------------------------------------------------------------------------
module gmc_checker
  import gmc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       motor_open_o,
  input logic       motor_close_o,
  input logic       led_moving_o,
  input logic       led_alarm_o,
  input logic [2:0] mode_o
);

  // input only stalls while a result is waiting
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_motor_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(motor_open_o && motor_close_o))
    else $error("both motor drives active");

  a_motor_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_open_o == (mode_o == MODE_OPENING)) &&
                    (motor_close_o == (mode_o == MODE_CLOSING)))
    else $error("motor drive does not match mode");

  a_led_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (led_moving_o == (motor_open_o || motor_close_o)) &&
                    (led_alarm_o == 1'b0 || mode_o == MODE_EMERGENCY ||
                     mode_o == MODE_ERROR))
    else $error("led state does not match mode");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o) &&
                                   $stable(led_alarm_o))
    else $error("stalled result item changed");

endmodule

bind gate_motor_controller gmc_checker u_gmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .motor_open_o  (motor_open_o),
  .motor_close_o (motor_close_o),
  .led_moving_o  (led_moving_o),
  .led_alarm_o   (led_alarm_o),
  .mode_o        (mode_o)
);
